// ===== hw/rtl/bba_pkg.sv =====
// Shared types, constants and helper functions of the buddy block allocator.
package bba_pkg;

    localparam int ORDER_LIMIT = 10;
    localparam int ORDERS      = ORDER_LIMIT + 1;
    localparam int ORDER_W     = 4;
    localparam int UNIT_W      = 10;
    localparam int MINB_W      = 21;
    localparam int BYTES_W     = 31;
    localparam int ALIGN_W     = 21;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCK = 2'd1;

    localparam logic [MINB_W-1:0]  MIN_BLOCK_RESET = 21'd256;
    localparam logic [BYTES_W-1:0] MAX_BLOCK_RESET = 31'd262144;

    typedef struct packed {
        logic [BYTES_W-1:0] request_bytes;
        logic [ALIGN_W-1:0] align_bytes;
    } request_word_t;

    typedef struct packed {
        logic               granted;
        logic [UNIT_W-1:0]  unit_offset;
        logic [ORDER_W-1:0] block_order;
        logic [BYTES_W-1:0] byte_offset;
    } result_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rem_start;
        logic rem_sel_off;
        logic load_size;
        logic check;
        logic load_out;
    } bba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic align_nz;
        logic rem_done;
        logic fail;
        logic out_room;
    } bba_status_t;

    // Smallest k (0..ORDER_LIMIT) with (mb << k) >= val; ORDERS when there is none.
    function automatic logic [ORDER_W-1:0] order_of(input logic [MINB_W-1:0] mb,
                                                   input logic [BYTES_W:0] val);
        logic [ORDER_W-1:0] res;
        logic [BYTES_W:0]   shifted;
        res = ORDER_W'(ORDERS);
        for (int k = ORDERS - 1; k >= 0; k--)
        begin
            shifted = {{(BYTES_W + 1 - MINB_W){1'b0}}, mb} << k;
            if (shifted >= val)
            begin
                res = ORDER_W'(k);
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/bba_rem.sv =====
// Iterative remainder unit, four restoring steps per cycle.
module bba_rem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bba_pkg::BYTES_W-1:0] dividend,
    input  logic [bba_pkg::ALIGN_W-1:0] divisor,
    output logic                        done,
    output logic [bba_pkg::ALIGN_W-1:0] remainder
);
    import bba_pkg::*;

    localparam int SH_W  = BYTES_W + 1;
    localparam int STEPS = 4;
    localparam int CNT_W = $clog2(SH_W / STEPS);

    logic [SH_W-1:0]    shift_reg, shift_next;
    logic [ALIGN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    always_comb
    begin
        logic [ALIGN_W:0] r;
        logic [SH_W-1:0]  sh;
        r  = {1'b0, rem_reg};
        sh = shift_reg;
        for (int i = 0; i < STEPS; i++)
        begin
            r  = {r[ALIGN_W-1:0], sh[SH_W-1]};
            sh = sh << 1;
            if (r >= {1'b0, divisor})
            begin
                r = r - {1'b0, divisor};
            end
        end
        rem_next   = r[ALIGN_W-1:0];
        shift_next = sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(SH_W / STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= {1'b0, dividend};
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/bba_dp.sv =====
// Datapath: configuration, free lists per order, used total, offsets and result register.
module bba_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          reg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0] reg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0] reg_data,
    input  bba_pkg::request_word_t        request,
    input  bba_pkg::bba_cmd_t             cmd,
    output bba_pkg::bba_status_t          status,
    output logic                          result_valid,
    input  logic                          result_stall,
    output bba_pkg::result_word_t         result
);
    import bba_pkg::*;

    logic [MINB_W-1:0]  min_reg;
    logic [BYTES_W-1:0] max_reg;
    logic [BYTES_W-1:0] used_reg;
    logic               pristine_reg;
    logic [ORDERS-1:0]  free_valid_reg;
    logic [UNIT_W-1:0]  free_unit_reg [ORDERS];

    logic [BYTES_W-1:0] req_reg;
    logic [ALIGN_W-1:0] align_reg;
    logic [BYTES_W:0]   size_reg;
    logic               grant_reg;
    logic [UNIT_W-1:0]  unit_reg;
    logic [ORDER_W-1:0] k_reg;
    logic [BYTES_W-1:0] prod_reg;
    logic               out_valid_reg;
    result_word_t       out_word_reg;

    logic [MINB_W-1:0]  mb;
    logic [ORDER_W-1:0] root_raw, root_order, k_comb;
    logic               align_nz;
    logic [BYTES_W-1:0] remaining;
    logic [ORDERS-1:0]  eff_valid, new_valid;
    logic [UNIT_W-1:0]  eff_unit [ORDERS];
    logic [UNIT_W-1:0]  new_unit [ORDERS];
    logic               found;
    logic [ORDER_W-1:0] j_sel;
    logic               fail;
    logic [BYTES_W:0]   used_sum;
    logic               rem_done;
    logic [ALIGN_W-1:0] rem_val;
    logic [BYTES_W-1:0] rem_dividend;
    logic [BYTES_W:0]   off_sum;
    result_word_t       word_next;

    assign mb         = (min_reg == '0) ? MINB_W'(1) : min_reg;
    assign root_raw   = order_of(mb, {1'b0, max_reg});
    assign root_order = (root_raw > ORDER_W'(ORDER_LIMIT)) ? ORDER_W'(ORDER_LIMIT) : root_raw;
    assign k_comb     = order_of(mb, size_reg);
    assign align_nz   = align_reg != '0;
    assign remaining  = (used_reg >= max_reg) ? '0 : max_reg - used_reg;

    // After a re-initialisation only the root block is free.
    always_comb
    begin
        for (int o = 0; o < ORDERS; o++)
        begin
            eff_valid[o] = pristine_reg ? (ORDER_W'(o) == root_order) : free_valid_reg[o];
            eff_unit[o]  = pristine_reg ? '0 : free_unit_reg[o];
        end
    end

    // Lowest free order at or above the requested one.
    always_comb
    begin
        found = 1'b0;
        j_sel = '0;
        for (int o = ORDERS - 1; o >= 0; o--)
        begin
            if (eff_valid[o] && (ORDER_W'(o) >= k_comb))
            begin
                found = 1'b1;
                j_sel = ORDER_W'(o);
            end
        end
    end

    assign fail = (k_comb > root_order) || (size_reg > {1'b0, remaining}) || !found;

    // Take the chosen block and free the right half at every order it is split through.
    always_comb
    begin
        for (int o = 0; o < ORDERS; o++)
        begin
            new_valid[o] = eff_valid[o];
            new_unit[o]  = eff_unit[o];
            if (ORDER_W'(o) == j_sel)
            begin
                new_valid[o] = 1'b0;
            end
            else if ((ORDER_W'(o) >= k_comb) && (ORDER_W'(o) < j_sel))
            begin
                new_valid[o] = 1'b1;
                new_unit[o]  = eff_unit[j_sel] + (UNIT_W'(1) << o);
            end
        end
    end

    assign used_sum = {1'b0, used_reg} + ({{(BYTES_W + 1 - MINB_W){1'b0}}, mb} << k_comb);

    assign rem_dividend = cmd.rem_sel_off ? prod_reg : {{(BYTES_W - MINB_W){1'b0}}, mb};

    bba_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.rem_start),
        .dividend  (rem_dividend),
        .divisor   (align_reg),
        .done      (rem_done),
        .remainder (rem_val)
    );

    assign off_sum = (align_nz && (rem_val != '0))
                   ? {1'b0, prod_reg} + {{(BYTES_W + 1 - ALIGN_W){1'b0}}, align_reg}
                     - {{(BYTES_W + 1 - ALIGN_W){1'b0}}, rem_val}
                   : {1'b0, prod_reg};

    always_comb
    begin
        word_next = '0;
        if (grant_reg)
        begin
            word_next.granted     = 1'b1;
            word_next.unit_offset = unit_reg;
            word_next.block_order = k_reg;
            word_next.byte_offset = off_sum[BYTES_W-1:0];
        end
    end

    // Control state: configuration, free lists, used total and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg        <= MIN_BLOCK_RESET;
            max_reg        <= MAX_BLOCK_RESET;
            used_reg       <= '0;
            pristine_reg   <= 1'b1;
            free_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (reg_we && ((reg_index == CFG_MIN_BLOCK) || (reg_index == CFG_MAX_BLOCK)))
            begin
                if (reg_index == CFG_MIN_BLOCK)
                begin
                    min_reg <= reg_data[MINB_W-1:0];
                end
                else
                begin
                    max_reg <= reg_data[BYTES_W-1:0];
                end
                used_reg     <= '0;
                pristine_reg <= 1'b1;
            end
            else if (cmd.check && !fail)
            begin
                free_valid_reg <= new_valid;
                pristine_reg   <= 1'b0;
                used_reg       <= used_sum[BYTES_W] ? {BYTES_W{1'b1}} : used_sum[BYTES_W-1:0];
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg   <= request.request_bytes;
            align_reg <= request.align_bytes;
        end
        if (cmd.load_size)
        begin
            size_reg <= (align_nz && (rem_val != '0))
                      ? {1'b0, req_reg} + {{(BYTES_W + 1 - ALIGN_W){1'b0}}, align_reg}
                      : {1'b0, req_reg};
        end
        if (cmd.check)
        begin
            grant_reg <= !fail;
            unit_reg  <= eff_unit[j_sel];
            k_reg     <= k_comb;
            prod_reg  <= {{(BYTES_W - UNIT_W){1'b0}}, eff_unit[j_sel]}
                       * {{(BYTES_W - MINB_W){1'b0}}, mb};
            if (!fail)
            begin
                free_unit_reg <= new_unit;
            end
        end
        if (cmd.load_out)
        begin
            out_word_reg <= word_next;
        end
    end

    assign status.align_nz = align_nz;
    assign status.rem_done = rem_done;
    assign status.fail     = fail;
    assign status.out_room = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
// Controller: sequences one request through padding, checking, allocation and rounding.
module bba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 request_valid,
    output logic                 request_stall,
    input  bba_pkg::bba_status_t status,
    output bba_pkg::bba_cmd_t    cmd
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_GO,
        ST_PAD,
        ST_SIZE,
        ST_CHECK,
        ST_OFF_GO,
        ST_OFF,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (request_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_PAD_GO;
                end
            end
            ST_PAD_GO:
            begin
                if (status.align_nz)
                begin
                    cmd.rem_start = 1'b1;
                    state_next    = ST_PAD;
                end
                else
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_PAD:
            begin
                if (status.rem_done)
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                cmd.load_size = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (!status.fail && status.align_nz)
                begin
                    state_next = ST_OFF_GO;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_OFF_GO:
            begin
                cmd.rem_start   = 1'b1;
                cmd.rem_sel_off = 1'b1;
                state_next      = ST_OFF;
            end
            ST_OFF:
            begin
                cmd.rem_sel_off = 1'b1;
                if (status.rem_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.rem_sel_off = 1'b1;
                if (status.out_room)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign request_stall = state_reg != ST_IDLE;

endmodule

// ===== hw/rtl/buddy_block_allocator_top.sv =====
// Top level of the buddy block allocator: controller, datapath and checks.
//
// Usage. A request word (request_bytes, align_bytes) is taken on the request
// channel at a rising edge with request_valid high and request_stall low. For
// every request exactly one result word (granted, unit_offset, block_order,
// byte_offset) appears on the result channel; a refused request gives a word of
// all zeros. Requests are worked on one at a time: request_stall is high from
// the accept until the result has been loaded into the output register.
// Without alignment the controller passes from the accept through the size load
// and the allocation check to the result load. With a nonzero alignment the
// remainder unit, which retires four quotient bits per cycle, first tests whether
// the alignment divides the minimum block and, on a grant, runs again to round
// the byte offset up. The output register lets the next request be taken while
// a result waits; if the receiver holds result_stall high, the word stays
// unchanged and the block waits before loading the following result. Reset, and
// every write of a configuration register, leaves only the root block free and
// clears the used byte total; there is no clearing pass. The user must write
// configuration only while the block is idle; the block itself does not
// enforce this.
module buddy_block_allocator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           request_valid,
    output logic                           request_stall,
    input  bba_pkg::request_word_t         request,
    output logic                           result_valid,
    input  logic                           result_stall,
    output bba_pkg::result_word_t          result,
    input  logic                           reg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  reg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0] reg_data
);
    import bba_pkg::*;

    bba_cmd_t    cmd;
    bba_status_t status;

    bba_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .status        (status),
        .cmd           (cmd)
    );

    bba_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .reg_we       (reg_we),
        .reg_index    (reg_index),
        .reg_data     (reg_data),
        .request      (request),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    // A refused request carries no offsets and no order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.granted) |->
        (result.unit_offset == '0 && result.block_order == '0 && result.byte_offset == '0))
        else $error("refused result word carries nonzero fields");

    // A granted block starts on a boundary of its own size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.granted) |->
        ((result.block_order <= ORDER_W'(ORDER_LIMIT)) &&
         ((result.unit_offset & ((UNIT_W'(1) << result.block_order) - UNIT_W'(1))) == '0)))
        else $error("granted block misaligned or order out of range");

    // Once a request is taken the channel is held off until its result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (request_valid && !request_stall) |=> request_stall)
        else $error("second request accepted while one is in progress");

    // The free lists are never updated in the cycle of an accept or a result load.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.check |-> !(cmd.accept || cmd.load_out))
        else $error("allocation overlaps accept or result load");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the buddy block allocator top level.
module tb;
    import bba_pkg::*;

    localparam int  NODES       = (2 << ORDER_LIMIT) - 1;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  PHASES      = 30;
    localparam int  PHASE_WORDS = 52;

    logic                  clk;
    logic                  rst_n;
    logic                  request_valid;
    logic                  request_stall;
    request_word_t         request;
    logic                  result_valid;
    logic                  result_stall;
    result_word_t          result;
    logic                  reg_we;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;

    buddy_block_allocator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .request       (request),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .reg_we        (reg_we),
        .reg_index     (reg_index),
        .reg_data      (reg_data)
    );

    // Words waiting to be offered, and results that the allocator owes us.
    request_word_t pending_requests[$];
    result_word_t  owed_results[$];

    // Our own copy of the allocator: configuration, buddy tree and byte total.
    logic [63:0] cur_min_block;
    logic [63:0] cur_max_block;
    logic [63:0] bytes_in_use;
    int          top_order;
    bit          node_free[NODES];

    int          mismatches;
    int          results_seen;
    int          cycle_count;
    int          send_gap;
    int          stall_left;
    bit          long_hold_done;

    always #5 clk = ~clk;

    // A zero minimum block behaves as a block of one byte.
    function automatic logic [63:0] unit_bytes();
        return (cur_min_block == 0) ? 64'd1 : cur_min_block;
    endfunction

    function automatic int size_order(input logic [63:0] size);
        int k;
        k = 0;
        while (k < 40 && (unit_bytes() << k) < size)
            k++;
        return k;
    endfunction

    function automatic int tree_node(input int order, input logic [63:0] unit);
        logic [63:0] level;
        level = 64'd1 << (ORDER_LIMIT - order);
        return int'(level - 1 + ((unit >> order) & (level - 1)));
    endfunction

    // Writing either register starts the allocator afresh: root free, nothing used.
    function automatic void restart_tree();
        top_order = size_order(cur_max_block);
        if (top_order > ORDER_LIMIT)
            top_order = ORDER_LIMIT;
        foreach (node_free[n])
            node_free[n] = 1'b0;
        node_free[tree_node(top_order, 0)] = 1'b1;
        bytes_in_use = 0;
    endfunction

    function automatic result_word_t predict_allocation(input request_word_t w);
        result_word_t r;
        logic [63:0]  mb;
        logic [63:0]  size;
        logic [63:0]  room;
        logic [63:0]  align;
        logic [63:0]  unit;
        logic [63:0]  offs;
        int           k;
        int           j;
        bit           found;
        r     = '0;
        mb    = unit_bytes();
        align = 64'(w.align_bytes);
        size  = 64'(w.request_bytes);
        unit  = 0;
        found = 1'b0;
        // An alignment that does not divide the smallest block costs extra bytes.
        if (align != 0 && (mb % align) != 0)
            size = size + align;
        k    = size_order(size);
        room = (bytes_in_use >= cur_max_block) ? 64'd0 : cur_max_block - bytes_in_use;
        if (k > top_order || size > room)
            return r;
        for (j = k; j <= top_order; j++)
        begin
            for (int i = 0; i < (1 << (top_order - j)); i++)
            begin
                if (node_free[tree_node(j, 64'(i) << j)])
                begin
                    node_free[tree_node(j, 64'(i) << j)] = 1'b0;
                    unit  = 64'(i) << j;
                    found = 1'b1;
                    break;
                end
            end
            if (found)
                break;
        end
        if (!found)
            return r;
        // Split down to the wanted order, releasing each right half.
        while (j > k)
        begin
            j--;
            node_free[tree_node(j, unit + (64'd1 << j))] = 1'b1;
        end
        bytes_in_use = bytes_in_use + (mb << k);
        if (bytes_in_use > 64'h7FFF_FFFF)
            bytes_in_use = 64'h7FFF_FFFF;
        offs = unit * mb;
        if (align != 0 && (offs % align) != 0)
            offs = (offs / align + 1) * align;
        r.granted     = 1'b1;
        r.unit_offset = unit[UNIT_W-1:0];
        r.block_order = k[ORDER_W-1:0];
        r.byte_offset = offs[BYTES_W-1:0];
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65)
            return 0;
        else if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Request sender. A word leaves when valid is high and stall is low; the
    // next one may follow at once or after a random gap.
    always @(posedge clk)
    begin
        bit fire;
        if (rst_n)
        begin
            fire = request_valid && !request_stall;
            if (fire)
            begin
                owed_results.push_back(predict_allocation(request));
                void'(pending_requests.pop_front());
                send_gap = pick_gap();
            end
            if (!request_valid || fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    request_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    request_valid <= 1'b1;
                    request       <= pending_requests[0];
                end
                else
                begin
                    request_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver and checker. Once, after a few hundred results, it holds
    // stall high for a long stretch so that the output register stays full and
    // the allocator has to stall the sender.
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word %p", result);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (result.granted !== want.granted
                        || result.unit_offset !== want.unit_offset
                        || result.block_order !== want.block_order
                        || result.byte_offset !== want.byte_offset)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result mismatch: expected %p, got %p", want, result);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (!long_hold_done && results_seen >= 300)
            begin
                long_hold_done = 1'b1;
                stall_left     = 400;
                result_stall   <= 1'b1;
            end
            else
            begin
                stall_left   = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                result_stall <= (stall_left > 0);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Waits until every queued word has gone and every result has come back,
    // then lets the allocator settle before the configuration changes.
    task automatic drain();
        while (pending_requests.size() > 0 || owed_results.size() > 0 || request_valid)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(posedge clk);
        reg_we    <= 1'b1;
        reg_index <= idx;
        reg_data  <= value[CFG_DATA_W-1:0];
        if (idx == CFG_MIN_BLOCK)
        begin
            cur_min_block = value & 64'h1F_FFFF;
            restart_tree();
        end
        else if (idx == CFG_MAX_BLOCK)
        begin
            cur_max_block = value & 64'h7FFF_FFFF;
            restart_tree();
        end
        @(posedge clk);
        reg_we <= 1'b0;
    endtask

    task automatic queue_request(input logic [63:0] bytes, input logic [63:0] align);
        request_word_t w;
        w.request_bytes = bytes[BYTES_W-1:0];
        w.align_bytes   = align[ALIGN_W-1:0];
        @(negedge clk);
        pending_requests.push_back(w);
    endtask

    function automatic logic [63:0] random_align();
        int p;
        p = $urandom_range(0, 9);
        if (p < 4)
            return 0;
        else if (p < 7)
            return 64'd1 << $urandom_range(0, 20);
        else if (p < 9)
            return $urandom_range(1, 1048576);
        return $urandom & 32'h1F_FFFF;
    endfunction

    // Sizes mostly sit near a power-of-two block so that grants, splits and
    // exhaustion of the tree all happen; a few words use any 31-bit value.
    function automatic logic [63:0] random_bytes();
        logic [63:0] span;
        if ($urandom_range(0, 19) == 0)
            return $urandom & 32'h7FFF_FFFF;
        span = unit_bytes() << $urandom_range(0, top_order + 1);
        if (span > 64'd1073741824)
            span = 64'd1073741824;
        return $urandom_range(0, int'(span));
    endfunction

    initial
    begin
        logic [63:0] mb;
        logic [63:0] mx;
        clk            = 1'b0;
        rst_n          = 1'b0;
        request_valid  = 1'b0;
        request        = '0;
        result_stall   = 1'b0;
        reg_we         = 1'b0;
        reg_index      = CFG_MIN_BLOCK;
        reg_data       = '0;
        mismatches     = 0;
        results_seen   = 0;
        cycle_count    = 0;
        send_gap       = 0;
        stall_left     = 0;
        long_hold_done = 1'b0;
        cur_min_block  = 64'(MIN_BLOCK_RESET);
        cur_max_block  = 64'(MAX_BLOCK_RESET);
        restart_tree();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset configuration: zero size, alignment that
        // divides the block and one that does not, field extremes, orders above
        // the root, and enough whole-region requests to exhaust the tree.
        queue_request(0, 0);
        queue_request(1, 1);
        queue_request(256, 256);
        queue_request(300, 0);
        queue_request(100, 96);
        queue_request(1000, 1048576);
        queue_request(64'h7FFF_FFFF, 64'h1F_FFFF);
        queue_request(1073741824, 0);
        queue_request(262145, 0);
        queue_request(65536, 0);
        queue_request(65536, 3);
        queue_request(131072, 0);
        queue_request(131072, 0);
        queue_request(512, 768);
        queue_request(0, 0);
        queue_request(4096, 4096);
        drain();

        // Configuration extremes, out-of-range indexes and a zero minimum block.
        write_reg(CFG_MIN_BLOCK, 1);
        write_reg(CFG_MAX_BLOCK, 1);
        queue_request(0, 0);
        queue_request(1, 0);
        queue_request(1, 2);
        drain();
        write_reg(CFG_MIN_BLOCK, 1048576);
        write_reg(CFG_MAX_BLOCK, 1073741824);
        write_reg(2'd2, 64'h7FFF_FFFF);
        write_reg(2'd3, 0);
        queue_request(1073741824, 0);
        queue_request(1048576, 1048576);
        queue_request(5, 64'h1F_FFFF);
        drain();
        write_reg(CFG_MIN_BLOCK, 0);
        queue_request(0, 0);
        queue_request(2, 3);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 3))
                0: mb = 64'd1 << $urandom_range(0, 20);
                1: mb = $urandom_range(1, 1048576);
                2: mb = $urandom_range(1, 64);
                default: mb = 64'd1 << $urandom_range(0, 8);
            endcase
            mx = mb << $urandom_range(0, 11);
            if ($urandom_range(0, 4) == 0)
                mx = $urandom_range(1, 1073741824);
            if (mx > 64'd1073741824)
                mx = 64'd1073741824;
            if (ph % 3 != 2)
                write_reg(CFG_MIN_BLOCK, mb);
            write_reg(CFG_MAX_BLOCK, mx);
            for (int n = 0; n < PHASE_WORDS; n++)
                queue_request(random_bytes(), random_align());
            drain();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
